// File: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and the shaping-curve generator for the exponential soft
// clipper: register codes, Q-format widths and the table entry function.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int GAIN_BITS      = 16;
    localparam int VOLUME_BITS    = 16;
    localparam int ROM_BITS       = 30;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_GAIN    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_VOLUME = 2'd1;

    localparam logic [GAIN_BITS-1:0]   DRIVE_GAIN_RESET    = 16'd256;
    localparam logic [GAIN_BITS-1:0]   DRIVE_GAIN_UNITY    = 16'd256;
    localparam logic [VOLUME_BITS-1:0] OUTPUT_VOLUME_RESET = 16'd4096;

    // log2(10) in Q16
    localparam longint unsigned LOG2_TEN_Q16 = 64'd217706;
    localparam logic [63:0]     ONE_Q30      = 64'd1 << 30;

    // bitwise integer square root
    function automatic logic [63:0] isqrt_u64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = value;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // curve point 1 - 2^(-x), x in Q16, result in Q30
    function automatic logic [ROM_BITS-1:0] shape_entry(input logic [63:0] x);
        logic [63:0] roots [1:16];
        logic [63:0] p;
        logic [63:0] ip;
        logic [15:0] fp;
        roots[1] = isqrt_u64(64'd1 << 59);
        for (int i = 2; i <= 16; i++) begin
            roots[i] = isqrt_u64(roots[i-1] << 30);
        end
        ip = x >> 16;
        fp = x[15:0];
        p  = ONE_Q30;
        for (int i = 1; i <= 16; i++) begin
            if (fp[16-i]) begin
                p = (p * roots[i] + (64'd1 << 29)) >> 30;
            end
        end
        p = (ip < 64'd63) ? (p >> ip) : 64'd0;
        return ROM_BITS'(ONE_Q30 - p);
    endfunction

endpackage

// File: design/esc_shape_lut.sv
// ----------------------------------------------------------------------------
// esc_shape_lut
// Two-stage curve lookup: reads neighboring table points, then interpolates
// linearly between them with a 16-bit fraction, rounded half up.
// ----------------------------------------------------------------------------
module esc_shape_lut #(
    parameter int ENTRIES  = 256,
    parameter int IDX_BITS = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IDX_BITS-1:0]          in_idx,
    input  logic [15:0]                  in_frac,
    input  logic                         in_neg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [esc_pkg::ROM_BITS-1:0] out_y,
    output logic                         out_neg
);

    localparam int RB = esc_pkg::ROM_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES);

    logic [RB-1:0] rom [0:ENTRIES];

    for (genvar k = 0; k <= ENTRIES; k++) begin : g_rom
        localparam longint unsigned XQ =
            (longint'(4) * longint'(k) * esc_pkg::LOG2_TEN_Q16 + longint'(ENTRIES / 2))
            / longint'(ENTRIES);
        assign rom[k] = esc_pkg::shape_entry(64'(XQ));
    end

    // stage a: table read
    logic                va_reg;
    logic [RB-1:0]       ta_lo_reg;
    logic [RB-1:0]       ta_hi_reg;
    logic [15:0]         fa_reg;
    logic                na_reg;
    logic                rdy_a;
    logic [IDX_BITS-1:0] sel_lo;
    logic [IDX_BITS-1:0] sel_hi;

    // stage b: interpolation
    logic                vb_reg;
    logic [RB-1:0]       yb_reg;
    logic                nb_reg;
    logic                rdy_b;
    logic signed [RB:0]  diff;
    logic [RB-1:0]       diff_mag;
    logic [RB+15:0]      step_prod;
    logic [RB-1:0]       step;
    logic [RB-1:0]       y_next;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        if (in_idx >= LAST_IDX) begin
            sel_lo = LAST_IDX;
            sel_hi = LAST_IDX;
        end else begin
            sel_lo = in_idx;
            sel_hi = in_idx + IDX_BITS'(1);
        end
    end

    always_comb begin
        diff      = $signed({1'b0, ta_hi_reg}) - $signed({1'b0, ta_lo_reg});
        diff_mag  = diff[RB] ? RB'(-diff) : diff[RB-1:0];
        step_prod = (RB+16)'(diff_mag) * (RB+16)'(fa_reg) + (RB+16)'(32768);
        step      = step_prod[RB+15:16];
        y_next    = diff[RB] ? (ta_lo_reg - step) : (ta_lo_reg + step);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                va_reg <= in_valid;
            end
            if (rdy_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            ta_lo_reg <= rom[sel_lo];
            ta_hi_reg <= rom[sel_hi];
            fa_reg    <= in_frac;
            na_reg    <= in_neg;
        end
        if (rdy_b) begin
            yb_reg <= y_next;
            nb_reg <= na_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_y     = yb_reg;
    assign out_neg   = nb_reg;

endmodule

// File: design/exponential_soft_clipper.sv
// ----------------------------------------------------------------------------
// exponential_soft_clipper
// Exponential waveshaper: drive gain, clamp, table curve 1 - 10^(-4a) with
// linear interpolation, sign restore and saturating output volume.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one signed Q1.15 sample per transaction on s_tdata
//   m_ channel: shaped sample on m_tdata, saturation flag on m_tuser
//   cfg channel: index 0 drive gain (Q8.8, zero means unity), index 1 output
//     volume (Q4.12); always ready, write only while the stream is idle
//   throughput: one transaction per cycle while m_tready is high, set by a
//     six-stage register pipeline (gain multiply, clamp and index, table
//     read, interpolate, volume multiply, round and saturate)
//   stall: each stage holds while the next is full, so bubbles close up and
//     s_tready stays high until every stage holds a sample
//   reset: aresetn low clears all stage valid bits and loads drive 1.0 and
//     volume 1.0
// ----------------------------------------------------------------------------
module exponential_soft_clipper #(
    parameter int SHAPE_TABLE_ENTRIES = 256,
    parameter int SAMPLE_BITS         = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // sample_out
    output logic [0:0]                            m_tuser,   // out_saturated
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [esc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [esc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int GAIN_FRAC  = FRAC_BITS + 8;
    localparam int PROD_BITS  = SAMPLE_BITS + esc_pkg::GAIN_BITS;
    localparam int IDX_BITS   = $clog2(SHAPE_TABLE_ENTRIES + 1);
    localparam int POS_BITS   = GAIN_FRAC + IDX_BITS;
    localparam int RB         = esc_pkg::ROM_BITS;
    localparam int Z_BITS     = RB + esc_pkg::VOLUME_BITS;
    localparam int Z_SHIFT    = 42 - FRAC_BITS;
    localparam int SUM_BITS   = Z_BITS + 1;
    localparam int Q_BITS     = SUM_BITS - Z_SHIFT;

    localparam logic [PROD_BITS-1:0] CLAMP_ONE  = PROD_BITS'(1) << GAIN_FRAC;
    localparam logic [SUM_BITS-1:0]  ROUND_HALF = SUM_BITS'(1) << (Z_SHIFT - 1);
    localparam logic [Q_BITS-1:0]    LIM_NEG    = Q_BITS'(1) << FRAC_BITS;
    localparam logic [Q_BITS-1:0]    LIM_POS    = LIM_NEG - Q_BITS'(1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {FRAC_BITS{1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [IDX_BITS-1:0]  LAST_IDX   = IDX_BITS'(SHAPE_TABLE_ENTRIES);

    // configuration registers
    logic [esc_pkg::GAIN_BITS-1:0]   drive_gain_reg;
    logic [esc_pkg::VOLUME_BITS-1:0] output_volume_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg    <= esc_pkg::DRIVE_GAIN_RESET;
            output_volume_reg <= esc_pkg::OUTPUT_VOLUME_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                esc_pkg::CFG_DRIVE_GAIN: begin
                    drive_gain_reg <= cfg_data;
                end
                esc_pkg::CFG_OUTPUT_VOLUME: begin
                    output_volume_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // stage 1: magnitude times drive
    logic                   v1_reg;
    logic                   n1_reg;
    logic [PROD_BITS-1:0]   p1_reg;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag;
    logic [esc_pkg::GAIN_BITS-1:0] gain_eff;
    logic [PROD_BITS-1:0]   p1_next;

    // stage 2: clamp and table position
    logic                   v2_reg;
    logic                   n2_reg;
    logic [IDX_BITS-1:0]    idx2_reg;
    logic [15:0]            frac2_reg;
    logic [PROD_BITS-1:0]   m_clamped;
    logic [POS_BITS-1:0]    pos;
    logic [GAIN_FRAC+15:0]  frac_wide;

    // stages 3 and 4: curve lookup
    logic                   lut_in_ready;
    logic                   lut_out_valid;
    logic [RB-1:0]          lut_y;
    logic                   lut_neg;

    // stage 5: volume multiply
    logic                   v5_reg;
    logic                   n5_reg;
    logic [Z_BITS-1:0]      z5_reg;

    // stage 6: round, saturate, sign
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_sat_reg;
    logic [SUM_BITS-1:0]    z_sum;
    logic [Q_BITS-1:0]      q;
    logic [Q_BITS-1:0]      limit;
    logic                   sat_next;
    logic [SAMPLE_BITS-1:0] q_clamped;
    logic [SAMPLE_BITS-1:0] sample_next;

    logic rdy1;
    logic rdy2;
    logic rdy5;
    logic rdy_out;

    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy5     = !v5_reg || rdy_out;
    assign rdy2     = !v2_reg || lut_in_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        raw      = s_tdata[SAMPLE_BITS-1:0];
        mag      = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
        gain_eff = (drive_gain_reg != '0) ? drive_gain_reg : esc_pkg::DRIVE_GAIN_UNITY;
        p1_next  = PROD_BITS'(mag) * PROD_BITS'(gain_eff);
    end

    always_comb begin
        m_clamped = (p1_reg > CLAMP_ONE) ? CLAMP_ONE : p1_reg;
        pos       = POS_BITS'(m_clamped) * POS_BITS'(SHAPE_TABLE_ENTRIES);
        frac_wide = {pos[GAIN_FRAC-1:0], 16'd0} >> GAIN_FRAC;
    end

    esc_shape_lut #(
        .ENTRIES  (SHAPE_TABLE_ENTRIES),
        .IDX_BITS (IDX_BITS)
    ) u_lut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_reg),
        .in_ready  (lut_in_ready),
        .in_idx    (idx2_reg),
        .in_frac   (frac2_reg),
        .in_neg    (n2_reg),
        .out_valid (lut_out_valid),
        .out_ready (rdy5),
        .out_y     (lut_y),
        .out_neg   (lut_neg)
    );

    always_comb begin
        z_sum       = SUM_BITS'(z5_reg) + ROUND_HALF;
        q           = z_sum[SUM_BITS-1:Z_SHIFT];
        limit       = n5_reg ? LIM_NEG : LIM_POS;
        sat_next    = q > limit;
        q_clamped   = sat_next ? limit[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];
        sample_next = n5_reg ? (~q_clamped + SAMPLE_BITS'(1)) : q_clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy5) begin
                v5_reg <= lut_out_valid;
            end
            if (rdy_out) begin
                m_tvalid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            n1_reg <= raw[SAMPLE_BITS-1];
            p1_reg <= p1_next;
        end
        if (rdy2) begin
            n2_reg    <= n1_reg;
            idx2_reg  <= pos[POS_BITS-1:GAIN_FRAC];
            frac2_reg <= frac_wide[15:0];
        end
        if (rdy5) begin
            n5_reg <= lut_neg;
            z5_reg <= Z_BITS'(lut_y) * Z_BITS'(output_volume_reg);
        end
        if (rdy_out) begin
            out_sample_reg <= sample_next;
            out_sat_reg    <= sat_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = TDATA_BITS'(out_sample_reg);
    assign m_tuser[0] = out_sat_reg;

`ifndef SYNTHESIS
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[SAMPLE_BITS-1:0] == SAMPLE_MAX ||
             m_tdata[SAMPLE_BITS-1:0] == SAMPLE_MIN))
        else $error("saturation flag without a full-scale sample");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (idx2_reg <= LAST_IDX))
        else $error("table index beyond the last curve point");
`endif

endmodule

// File: tb/tb_exponential_soft_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exponential_soft_clipper
// Self-checking bench for the exponential soft clipper. A bit-exact shaping
// predictor (its own curve table, gain, clamp, interpolation and saturating
// volume) forms the expected sample and flag for every accepted input. Named
// tests cover the sample and register extremes; random traffic then runs
// over gain and volume settings, idling both streams but in its last phase.
// ----------------------------------------------------------------------------
module tb_exponential_soft_clipper;

    localparam int CURVE_POINTS = 256;
    localparam int PHASE_ITEMS  = 50;
    localparam int PHASES       = 9;
    localparam longint unsigned LOG2_OF_TEN_Q16 = 64'd217706;
    localparam longint unsigned UNIT_Q30        = 64'd1 << 30;
    localparam longint unsigned FULL_SCALE_Q23  = 64'd1 << 23;

    localparam logic [esc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [esc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

    typedef struct packed {
        logic [15:0] sample;
        logic        saturated;
    } shaped_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [esc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [esc_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic [15:0]     drive_setting  = esc_pkg::DRIVE_GAIN_RESET;
    logic [15:0]     volume_setting = esc_pkg::OUTPUT_VOLUME_RESET;
    longint unsigned curve_q30 [0:CURVE_POINTS];
    shaped_t         pending_shapes [$];
    int              error_count = 0;
    bit              steady_flow = 1'b0;
    int              stall_left  = 0;

    exponential_soft_clipper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 1 - 2^(-x) with x = 4 * k * log2(10) / N, in Q30
    task automatic build_curve_table();
        longint unsigned halving_roots [1:16];
        longint unsigned x;
        longint unsigned whole;
        longint unsigned frac_bits;
        longint unsigned p;
        halving_roots[1] = int_sqrt(64'd1 << 59);
        for (int i = 2; i <= 16; i++) begin
            halving_roots[i] = int_sqrt(halving_roots[i-1] << 30);
        end
        for (int k = 0; k <= CURVE_POINTS; k++) begin
            x = (64'd4 * longint'(k) * LOG2_OF_TEN_Q16 + CURVE_POINTS / 2) / CURVE_POINTS;
            whole     = x >> 16;
            frac_bits = x & 64'hFFFF;
            p         = UNIT_Q30;
            for (int i = 1; i <= 16; i++) begin
                if (((frac_bits >> (16 - i)) & 64'd1) != 0) begin
                    p = (p * halving_roots[i] + (64'd1 << 29)) >> 30;
                end
            end
            p = (whole < 63) ? (p >> whole) : 64'd0;
            curve_q30[k] = UNIT_Q30 - p;
        end
    endtask

    function automatic shaped_t shape_sample(logic [15:0] raw);
        logic            negative;
        longint unsigned mag;
        longint unsigned m;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac16;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned y;
        longint unsigned q;
        longint unsigned limit;
        shaped_t         r;
        negative = raw[15];
        mag = negative ? (64'd65536 - 64'(raw)) : 64'(raw);
        m   = (drive_setting != 0) ? mag * 64'(drive_setting) : (mag << 8);
        if (m > FULL_SCALE_Q23) m = FULL_SCALE_Q23;
        pos = m * CURVE_POINTS;
        idx = pos >> 23;
        if (idx >= CURVE_POINTS) begin
            y = curve_q30[CURVE_POINTS];
        end else begin
            frac16 = ((pos & (FULL_SCALE_Q23 - 1)) << 16) >> 23;
            lo = curve_q30[idx];
            hi = curve_q30[idx + 1];
            if (hi < lo) begin
                y = lo - (((lo - hi) * frac16 + 64'd32768) >> 16);
            end else begin
                y = lo + (((hi - lo) * frac16 + 64'd32768) >> 16);
            end
        end
        q = (y * 64'(volume_setting) + (64'd1 << 26)) >> 27;
        limit = negative ? 64'd32768 : 64'd32767;
        r.saturated = (q > limit);
        if (r.saturated) q = limit;
        r.sample = negative ? 16'(64'd0 - q) : 16'(q);
        return r;
    endfunction

    task automatic send_sample(input logic [15:0] value);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_shapes.push_back(shape_sample(value));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_shapes.size() != 0) @(posedge aclk);
    endtask

    task automatic set_register(input logic [esc_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [esc_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            esc_pkg::CFG_DRIVE_GAIN:    drive_setting  = value;
            esc_pkg::CFG_OUTPUT_VOLUME: volume_setting = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        int mag_pick;
        case ($urandom_range(0, 5))
            0: mag_pick = $urandom_range(0, 255);
            1: mag_pick = $urandom_range(0, 4095);
            2: mag_pick = 32768 - $urandom_range(0, 15);
            default: return 16'($urandom_range(0, 65535));
        endcase
        return $urandom_range(0, 1) ? 16'(mag_pick) : 16'(-mag_pick);
    endfunction

    task automatic test_sample_extremes();
        logic [15:0] directed [8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                                      16'h8000, 16'h4000, 16'h5555, 16'hAAAA};
        foreach (directed[i]) send_sample(directed[i]);
        drain_results();
    endtask

    task automatic test_drive_extremes();
        set_register(esc_pkg::CFG_DRIVE_GAIN, 16'd0);
        send_sample(16'h4000);
        send_sample(16'hCFC7);
        drain_results();
        set_register(esc_pkg::CFG_DRIVE_GAIN, 16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        drain_results();
        set_register(esc_pkg::CFG_DRIVE_GAIN, 16'd1);
        send_sample(16'h7FFF);
        drain_results();
        set_register(esc_pkg::CFG_DRIVE_GAIN, esc_pkg::DRIVE_GAIN_UNITY);
    endtask

    task automatic test_volume_extremes();
        set_register(esc_pkg::CFG_OUTPUT_VOLUME, 16'd0);
        send_sample(16'h7FFF);
        drain_results();
        // positive and negative overflow, then an unsaturated small value
        set_register(esc_pkg::CFG_OUTPUT_VOLUME, 16'hFFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0064);
        drain_results();
        set_register(esc_pkg::CFG_OUTPUT_VOLUME, esc_pkg::OUTPUT_VOLUME_RESET);
    endtask

    task automatic test_spare_registers();
        set_register(CFG_SPARE_LOW, 16'hFFFF);
        set_register(CFG_SPARE_HIGH, 16'h0000);
        send_sample(16'h2000);
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            steady_flow = (phase == PHASES - 1);
            case ($urandom_range(0, 5))
                0: set_register(esc_pkg::CFG_DRIVE_GAIN, 16'd0);
                1: set_register(esc_pkg::CFG_DRIVE_GAIN, 16'hFFFF);
                2: set_register(esc_pkg::CFG_DRIVE_GAIN, 16'($urandom_range(1, 255)));
                3: set_register(esc_pkg::CFG_DRIVE_GAIN, 16'($urandom_range(256, 2048)));
                default: set_register(esc_pkg::CFG_DRIVE_GAIN,
                                      16'($urandom_range(0, 65535)));
            endcase
            case ($urandom_range(0, 4))
                0: set_register(esc_pkg::CFG_OUTPUT_VOLUME, 16'd0);
                1: set_register(esc_pkg::CFG_OUTPUT_VOLUME, 16'hFFFF);
                2: set_register(esc_pkg::CFG_OUTPUT_VOLUME, esc_pkg::OUTPUT_VOLUME_RESET);
                3: set_register(esc_pkg::CFG_OUTPUT_VOLUME, 16'($urandom_range(1, 8191)));
                default: set_register(esc_pkg::CFG_OUTPUT_VOLUME,
                                      16'($urandom_range(0, 65535)));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                set_register($urandom_range(0, 1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                             16'($urandom_range(0, 65535)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(random_sample());
            drain_results();
        end
    endtask

    // receiver stalls in random bursts
    always @(posedge aclk) begin
        if (!aresetn || steady_flow) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // check every result transaction against the oldest prediction
    always @(posedge aclk) begin
        shaped_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_shapes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_shapes.pop_front();
                if (m_tdata !== want.sample) begin
                    $display("%0t: sample_out mismatch, expected %h, actual %h",
                             $time, want.sample, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== want.saturated) begin
                    $display("%0t: out_saturated mismatch, expected %b, actual %b",
                             $time, want.saturated, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        build_curve_table();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sample_extremes();
        test_drive_extremes();
        test_volume_extremes();
        test_spare_registers();
        test_random_traffic();
        s_tvalid <= 1'b0;
        for (int c = 0; c < 5000 && pending_shapes.size() != 0; c++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_shapes.size() != 0) begin
            $display("%0t: %0d results missing, expected %h/%b, actual none", $time,
                     pending_shapes.size(), pending_shapes[0].sample,
                     pending_shapes[0].saturated);
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/esc_pkg.sv
design/esc_shape_lut.sv
design/exponential_soft_clipper.sv
tb/tb_exponential_soft_clipper.sv
